FILE: sv/hid_keyboard_report_key_queue_top_defines.svh
// Assertion macros used by the key queue datapath.
// Define ASSERT_OFF to compile the assertions out.
`ifndef HID_KEYBOARD_REPORT_KEY_QUEUE_TOP_DEFINES_SVH
`define HID_KEYBOARD_REPORT_KEY_QUEUE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define KQ_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define KQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KQ_ASSERT(label, expr, msg)
`define KQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: sv/hkq_pkg.sv
`default_nettype none
package hkq_pkg;

  localparam int RING_SLOTS_DEF = 64;
  localparam int KEY_BITS_DEF   = 9;
  localparam int MAP_DEPTH      = 1024;
  localparam int NUM_SLOTS      = 6;
  localparam int ESC_CODE       = 27;

  localparam logic [7:0] SHIFT_MASK    = 8'h22;
  localparam logic [7:0] CTRL_MASK     = 8'h11;
  localparam logic [7:0] ROLLOVER_CODE = 8'h01;
  localparam logic [2:0] LAST_SLOT     = 3'd5;

  typedef enum logic [2:0] {
    ACT_REPORT = 3'd0,
    ACT_POP    = 3'd1,
    ACT_UNGET  = 3'd2,
    ACT_ESC    = 3'd3,
    ACT_MAP    = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SLOT_CHECK,
    ST_SLOT_PUSH,
    ST_REPORT_END,
    ST_POP_WAIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_RP,
    RD_CURSOR,
    RD_NEXT
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_item;
    logic    slot_inc;
    logic    map_rd;
    logic    slot_push;
    logic    save_prev;
    logic    pop_unget;
    logic    pop_ring;
    logic    set_unget;
    logic    esc_unget;
    logic    esc_hit;
    logic    ring_rd_en;
    rd_sel_t ring_rd_sel;
    logic    cursor_load_rp;
    logic    cursor_step;
    logic    shift_write;
    logic    wp_dec;
    logic    map_wr;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    report_ok;
    logic    unget_full;
    logic    unget_esc;
    logic    ring_empty;
    logic    slot_new;
    logic    last_slot;
    logic    cursor_at_wp;
    logic    next_at_wp;
    logic    rdata_esc;
    logic    out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: sv/hkq_ctrl.sv
`default_nettype none
module hkq_ctrl
  import hkq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_DONE;
        case (status.action)
          ACT_REPORT: begin
            if (status.report_ok) begin
              state_next = ST_SLOT_CHECK;
            end
          end
          ACT_POP: begin
            if (status.unget_full) begin
              cmd.pop_unget = 1'b1;
            end else if (!status.ring_empty) begin
              cmd.ring_rd_en  = 1'b1;
              cmd.ring_rd_sel = RD_RP;
              state_next      = ST_POP_WAIT;
            end
          end
          ACT_UNGET: begin
            cmd.set_unget = 1'b1;
          end
          ACT_ESC: begin
            if (status.unget_esc) begin
              cmd.esc_unget = 1'b1;
            end else begin
              cmd.cursor_load_rp = 1'b1;
              state_next         = ST_SCAN_RD;
            end
          end
          ACT_MAP: begin
            cmd.map_wr = 1'b1;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_SLOT_CHECK: begin
        if (status.slot_new) begin
          cmd.map_rd = 1'b1;
          state_next = ST_SLOT_PUSH;
        end else if (status.last_slot) begin
          state_next = ST_REPORT_END;
        end else begin
          cmd.slot_inc = 1'b1;
        end
      end
      ST_SLOT_PUSH: begin
        cmd.slot_push = 1'b1;
        if (status.last_slot) begin
          state_next = ST_REPORT_END;
        end else begin
          cmd.slot_inc = 1'b1;
          state_next   = ST_SLOT_CHECK;
        end
      end
      ST_REPORT_END: begin
        cmd.save_prev = 1'b1;
        state_next    = ST_DONE;
      end
      ST_POP_WAIT: begin
        cmd.pop_ring = 1'b1;
        state_next   = ST_DONE;
      end
      ST_SCAN_RD: begin
        if (status.cursor_at_wp) begin
          state_next = ST_DONE;
        end else begin
          cmd.ring_rd_en  = 1'b1;
          cmd.ring_rd_sel = RD_CURSOR;
          state_next      = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (status.rdata_esc) begin
          cmd.esc_hit = 1'b1;
          state_next  = ST_SHIFT_RD;
        end else begin
          cmd.cursor_step = 1'b1;
          state_next      = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (status.next_at_wp) begin
          cmd.wp_dec = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.ring_rd_en  = 1'b1;
          cmd.ring_rd_sel = RD_NEXT;
          state_next      = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd.shift_write = 1'b1;
        cmd.cursor_step = 1'b1;
        state_next      = ST_SHIFT_RD;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/hkq_datapath.sv
`default_nettype none
`include "hid_keyboard_report_key_queue_top_defines.svh"
module hkq_datapath
  import hkq_pkg::*;
#(
  parameter int RING_SLOTS = RING_SLOTS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [87:0] s_tdata,
  input  logic [3:0]  s_tuser,
  input  cmd_t        cmd,
  output status_t     status,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tuser
);

  localparam int PW = $clog2(RING_SLOTS);
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_SLOTS - 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PTR_LAST : p - PW'(1);
  endfunction

  // Captured input word.
  logic [2:0]  item_action;
  logic        item_ok;
  logic [7:0]  item_mods;
  logic [7:0]  item_keys [NUM_SLOTS];
  logic [9:0]  item_map_index;
  logic [8:0]  item_map_value;
  logic [9:0]  item_unget;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_action    <= s_tuser[2:0];
      item_ok        <= s_tuser[3];
      item_mods      <= s_tdata[7:0];
      for (int i = 0; i < NUM_SLOTS; i++) begin
        item_keys[i] <= s_tdata[8*i+8 +: 8];
      end
      item_map_index <= s_tdata[65:56];
      item_map_value <= s_tdata[74:66];
      item_unget     <= s_tdata[84:75];
    end
  end

  // State of the queue.
  logic [7:0]    prev_keys [NUM_SLOTS];
  logic [9:0]    unget;
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW-1:0] cursor;
  logic [2:0]    slot;

  logic [KEY_BITS-1:0] key_map [MAP_DEPTH];
  logic [KEY_BITS-1:0] key_ring [RING_SLOTS];
  logic [KEY_BITS-1:0] map_rdata;
  logic [KEY_BITS-1:0] ring_rdata;

  logic [7:0] cur_key;
  logic       held;
  logic       shift_bit;
  logic       ctrl_bit;
  logic       ring_full;
  logic       map_hit;
  logic       do_push;
  logic [PW-1:0] cursor_inc;
  logic [PW-1:0] ring_raddr;
  logic          ring_we;
  logic [PW-1:0] ring_waddr;
  logic [KEY_BITS-1:0] ring_wdata;

  assign cur_key    = item_keys[slot];
  assign shift_bit  = |(item_mods & SHIFT_MASK);
  assign ctrl_bit   = |(item_mods & CTRL_MASK);
  assign ring_full  = (ptr_inc(wp) == rp);
  assign map_hit    = (map_rdata != '0);
  assign do_push    = cmd.slot_push && map_hit && !ring_full;
  assign cursor_inc = ptr_inc(cursor);

  always_comb begin
    held = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (prev_keys[i] == cur_key) begin
        held = 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd.ring_rd_sel)
      RD_RP:     ring_raddr = rp;
      RD_CURSOR: ring_raddr = cursor;
      RD_NEXT:   ring_raddr = cursor_inc;
      default:   ring_raddr = rp;
    endcase
  end

  always_comb begin
    ring_we    = do_push || cmd.shift_write;
    ring_waddr = cmd.shift_write ? cursor : wp;
    ring_wdata = cmd.shift_write ? ring_rdata : map_rdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.map_wr) begin
      key_map[item_map_index] <= KEY_BITS'(item_map_value);
    end
    if (cmd.map_rd) begin
      map_rdata <= key_map[{ctrl_bit, shift_bit, cur_key}];
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      key_ring[ring_waddr] <= ring_wdata;
    end
    if (cmd.ring_rd_en) begin
      ring_rdata <= key_ring[ring_raddr];
    end
  end

  // Per-word result fields.
  logic       res_key_valid;
  logic [8:0] res_key_value;
  logic       res_esc;
  logic [2:0] res_pushed;
  logic [2:0] res_dropped;
  logic       pending;

  assign pending = !unget[9] || (wp != rp);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        prev_keys[i] <= '0;
      end
      unget         <= '1;
      wp            <= '0;
      rp            <= '0;
      cursor        <= '0;
      slot          <= '0;
      res_key_valid <= 1'b0;
      res_key_value <= '0;
      res_esc       <= 1'b0;
      res_pushed    <= '0;
      res_dropped   <= '0;
    end else begin
      if (cmd.load_item) begin
        slot          <= '0;
        res_key_valid <= 1'b0;
        res_key_value <= '0;
        res_esc       <= 1'b0;
        res_pushed    <= '0;
        res_dropped   <= '0;
      end
      if (cmd.slot_inc) begin
        slot <= slot + 3'd1;
      end
      if (cmd.slot_push && map_hit) begin
        if (ring_full) begin
          res_dropped <= res_dropped + 3'd1;
        end else begin
          res_pushed <= res_pushed + 3'd1;
        end
      end
      if (do_push) begin
        wp <= ptr_inc(wp);
      end else if (cmd.wp_dec) begin
        wp <= ptr_dec(wp);
      end
      if (cmd.save_prev) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          prev_keys[i] <= item_keys[i];
        end
      end
      if (cmd.pop_unget) begin
        res_key_valid <= 1'b1;
        res_key_value <= unget[8:0];
        unget         <= '1;
      end
      if (cmd.pop_ring) begin
        res_key_valid <= 1'b1;
        res_key_value <= 9'(ring_rdata);
        rp            <= ptr_inc(rp);
      end
      if (cmd.set_unget) begin
        unget <= item_unget[9] ? '1 : item_unget;
      end
      if (cmd.esc_unget) begin
        res_esc <= 1'b1;
        unget   <= '1;
      end
      if (cmd.esc_hit) begin
        res_esc <= 1'b1;
      end
      if (cmd.cursor_load_rp) begin
        cursor <= rp;
      end else if (cmd.cursor_step) begin
        cursor <= cursor_inc;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= res_key_valid;
      m_tdata <= {7'd0, res_dropped, res_pushed, pending, res_esc, res_key_value};
    end
  end

  always_comb begin
    status.action       = action_t'(item_action);
    status.report_ok    = item_ok;
    status.unget_full   = !unget[9];
    status.unget_esc    = (unget == 10'(ESC_CODE));
    status.ring_empty   = (wp == rp);
    status.slot_new     = (cur_key != '0) && (cur_key != ROLLOVER_CODE) && !held;
    status.last_slot    = (slot == LAST_SLOT);
    status.cursor_at_wp = (cursor == wp);
    status.next_at_wp   = (cursor_inc == wp);
    status.rdata_esc    = (ring_rdata == KEY_BITS'(ESC_CODE));
    status.out_free     = !m_tvalid || m_tready;
  end

  `KQ_ASSERT(a_pop_nonempty, !cmd.pop_ring || (wp != rp), "ring pop issued on an empty ring")
  `KQ_ASSERT(a_wp_dec_nonempty, !cmd.wp_dec || (wp != rp), "ESC removal on an empty ring")
  `KQ_ASSERT(a_out_free, !cmd.out_load || !m_tvalid || m_tready, "result word overwritten")
  `KQ_ASSERT_NEXT(a_full_hold, cmd.slot_push && ring_full, $stable(wp), "push into full ring")

endmodule
`default_nettype wire

FILE: sv/hid_keyboard_report_key_queue_top.sv
// Boot-keyboard report decoder with a key queue.
// The input channel (s_tvalid/s_tready) carries one command word: a
// keyboard report, a pop, an unget write, an ESC removal or a key map
// write, chosen by the action field in s_tuser. The output channel
// (m_tvalid/m_tready) returns exactly one result word for every input word.
// The block works on one word at a time. A map write, an unget write or a
// pop served from the unget slot is decoded and its result word loaded;
// a pop from the ring reads the ring first. A report checks each slot in
// turn and does a lookup for each newly pressed key, where each key map
// lookup is one read of the key map memory. ESC removal clears an ESC held
// in the unget slot, else walks the ring through its single read port: it
// scans from the read pointer and moves each entry after the ESC down one.
// While a result word waits for m_tready the next input word is accepted
// and processed; it then waits at its last step until the output register
// is free. Reset empties the ring and the unget slot and clears the
// previous report; the key map and ring contents are left as they are, and
// the key map must be loaded before reports are sent.
`default_nettype none
module hid_keyboard_report_key_queue_top
  import hkq_pkg::*;
#(
  parameter int RING_SLOTS = RING_SLOTS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Low to high: modifier_bits[7:0], key_slot_0..key_slot_5 (8 bits each),
  // map_index[9:0], map_value[8:0], unget_value[9:0], zero pad[2:0].
  input  logic [87:0] s_tdata,
  // Low to high: action[2:0], report_ok.
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Low to high: key_value[8:0], esc_found, pending, keys_pushed[2:0],
  // keys_dropped[2:0], zero pad[6:0].
  output logic [23:0] m_tdata,
  // key_valid.
  output logic        m_tuser
);

  cmd_t    cmd;
  status_t status;

  // The controller sequences each word; the datapath holds the queue state,
  // the key map and ring memories and the output register.
  hkq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hkq_datapath #(
    .RING_SLOTS (RING_SLOTS),
    .KEY_BITS   (KEY_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire
